// ===== hdl/clcd_pkg.sv =====
`default_nettype none

package clcd_pkg;

   // request operation codes
   localparam logic [1:0] OP_INIT = 2'd0;
   localparam logic [1:0] OP_POS  = 2'd1;
   localparam logic [1:0] OP_CUR  = 2'd2;

   // bus command values
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;

   // reset value of the hold time register
   localparam logic [7:0] HOLD_RESET = 8'd5;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // byte index range of one job (init has five command bytes)
   localparam int BYTE_W = 3;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] column;
      logic       row;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic       read_write;
      logic [7:0] bus_data;
      logic       enable_level;
      logic [7:0] hold_time;
      logic       last_phase;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_POS,
      JOB_CUR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   addr;
      logic [7:0]   character;
   } job_type;

   // init command bytes in the order they go out
   function automatic logic [7:0] init_cmd(input logic [BYTE_W-1:0] idx);
      logic [7:0] cmd;
      unique case (idx)
         3'd0:    cmd = 8'h38;
         3'd1:    cmd = 8'h01;
         3'd2:    cmd = 8'h0C;
         3'd3:    cmd = 8'h06;
         3'd4:    cmd = CMD_SET_ADDR;
         default: cmd = CMD_SET_ADDR;
      endcase
      return cmd;
   endfunction

   // index of the final byte of a job
   function automatic logic [BYTE_W-1:0] last_byte_idx(input job_kind_type kind);
      logic [BYTE_W-1:0] idx;
      unique case (kind)
         JOB_INIT: idx = 3'd4;
         JOB_POS:  idx = 3'd1;
         JOB_CUR:  idx = 3'd0;
         default:  idx = 3'd0;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/char_lcd_write_sequencer.sv =====
// 8-bit character display write sequencer.
// Requests come in on req_valid/req_ready with req_payload: init, write a
// character at a row/column, or write a character at the current address.
// Each request turns into a run of bus phases on rsp_valid/rsp_ready, one
// phase per result: setup (enable low), pulse (enable high), release (enable
// low, hold 0) for every byte, with last_phase set on the final phase.
// Init gives 16 phases, positioned write 6, current-address write 3;
// operation code 3 is accepted and gives nothing.
// csr_valid/csr_ready/csr_data writes the hold time in ms (reset 5); the
// port is always ready. The user writes it only while the block is idle;
// the block itself does not enforce this. A request is written into a
// two-entry queue, and its first phase is registered in the phase register
// once the back sequencer pops it. The back sequencer sends one phase per
// cycle while a job is waiting and the receiver is ready. When the receiver
// stalls, the phase register holds and the sequencer waits; requests keep
// entering until the queue fills. Synchronous active-high reset empties the
// queue, drops any phase in flight and sets the hold time back to 5.
`default_nettype none

module char_lcd_write_sequencer (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  clcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output clcd_pkg::rsp_type rsp_payload,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [7:0]        csr_data
);
   import clcd_pkg::*;

   logic [7:0] hold_ff;
   logic       q_ready, q_push, head_valid, pop;
   job_type    q_job, head_job;

   // hold time register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else if (csr_valid) begin
         hold_ff <= csr_data;
      end
   end

   clcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   clcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .not_full   (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   clcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .hold_ms     (hold_ff),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hdl/clcd_front.sv =====
`default_nettype none

module clcd_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  clcd_pkg::req_type req_payload,
   input  wire              q_ready,
   output logic             q_push,
   output clcd_pkg::job_type q_job
);
   import clcd_pkg::*;

   // accept whenever the queue has room; unused operation is dropped
   assign req_ready = q_ready;

   // classify the request into a job
   always_comb begin
      q_job.character = req_payload.character;
      // 0x80 + row*0x40 + column, column always below 0x40
      q_job.addr      = {1'b1, req_payload.row, req_payload.column};
      q_push          = req_valid && q_ready;
      unique case (req_payload.operation)
         OP_INIT: q_job.kind = JOB_INIT;
         OP_POS:  q_job.kind = JOB_POS;
         OP_CUR:  q_job.kind = JOB_CUR;
         default: begin
            q_job.kind = JOB_CUR;
            q_push     = 1'b0;
         end
      endcase
   end

   // a dropped request never reaches the queue
   a_no_push_unused: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_payload.operation != OP_INIT && req_payload.operation != OP_POS
       && req_payload.operation != OP_CUR) |-> !q_push)
      else $error("unused operation pushed");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_ready && req_valid))
      else $error("push without room");

   a_addr_top_bit: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_job.addr[7])
      else $error("set address command lost its top bit");

endmodule

`default_nettype wire

// ===== hdl/clcd_queue.sv =====
`default_nettype none

module clcd_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  clcd_pkg::job_type push_job,
   output logic              not_full,
   input  wire               pop,
   output logic              head_valid,
   output clcd_pkg::job_type head_job
);
   import clcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign not_full   = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue overfilled");

   a_ptrs_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers apart while empty");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(1) && do_pop && !do_push) |=> !head_valid)
      else $error("last entry popped but queue still valid");

endmodule

`default_nettype wire

// ===== hdl/clcd_back.sv =====
`default_nettype none

module clcd_back (
   input  wire               clock,
   input  wire               reset,
   input  wire  [7:0]        hold_ms,
   input  wire               head_valid,
   input  clcd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output clcd_pkg::rsp_type rsp_payload
);
   import clcd_pkg::*;

   typedef enum logic [1:0] {
      PH_SETUP,
      PH_PULSE,
      PH_RELEASE
   } phase_type;

   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   phase_type         ph_ff, ph_in;
   logic              lead_done_ff, lead_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   job_type    cur_job;
   logic       fire, lead, last_byte, done;
   logic       byte_rs;
   logic [7:0] byte_data;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // pick the byte of the current job
   always_comb begin
      cur_job   = busy_ff ? job_ff : head_job;
      lead      = (cur_job.kind == JOB_INIT) && !lead_done_ff;
      last_byte = (byte_ff == last_byte_idx(cur_job.kind));
      unique case (cur_job.kind)
         JOB_INIT: begin
            byte_rs   = 1'b0;
            byte_data = init_cmd(byte_ff);
         end
         JOB_POS: begin
            byte_rs   = (byte_ff != '0);
            byte_data = (byte_ff == '0) ? cur_job.addr : cur_job.character;
         end
         JOB_CUR: begin
            byte_rs   = 1'b1;
            byte_data = cur_job.character;
         end
         default: begin
            byte_rs   = 1'b0;
            byte_data = '0;
         end
      endcase
   end

   // phase generation and sequencing
   always_comb begin
      fire         = (busy_ff || head_valid) && (!rsp_valid_ff || rsp_ready);
      pop          = fire && !busy_ff;
      done         = 1'b0;
      busy_in      = busy_ff;
      job_in       = pop ? head_job : job_ff;
      byte_in      = byte_ff;
      ph_in        = ph_ff;
      lead_done_in = lead_done_ff;

      rsp_in.reg_select   = byte_rs;
      rsp_in.read_write   = 1'b0;
      rsp_in.bus_data     = byte_data;
      rsp_in.enable_level = 1'b0;
      rsp_in.hold_time    = hold_ms;
      rsp_in.last_phase   = 1'b0;

      if (lead) begin
         // init lead phase: everything low
         rsp_in.reg_select = 1'b0;
         rsp_in.bus_data   = '0;
         rsp_in.hold_time  = '0;
         lead_done_in      = fire ? 1'b1 : lead_done_ff;
      end else begin
         unique case (ph_ff)
            PH_SETUP: begin
               ph_in = PH_PULSE;
            end
            PH_PULSE: begin
               rsp_in.enable_level = 1'b1;
               ph_in               = PH_RELEASE;
            end
            PH_RELEASE: begin
               rsp_in.hold_time  = '0;
               rsp_in.last_phase = last_byte;
               ph_in             = PH_SETUP;
               done              = last_byte;
               byte_in           = last_byte ? '0 : byte_ff + 1'b1;
            end
            default: begin
               ph_in = PH_SETUP;
            end
         endcase
         if (!fire) begin
            ph_in   = ph_ff;
            byte_in = byte_ff;
         end
      end

      if (fire) begin
         busy_in = !done;
         if (done) begin
            lead_done_in = 1'b0;
         end
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         byte_ff      <= '0;
         ph_ff        <= PH_SETUP;
         lead_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         byte_ff      <= byte_in;
         ph_ff        <= ph_in;
         lead_done_ff <= lead_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (byte_ff == '0 && ph_ff == PH_SETUP && !lead_done_ff))
      else $error("sequencer idle with counters not at start");

   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (byte_ff <= last_byte_idx(job_ff.kind)))
      else $error("byte index past end of job");

   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.last_phase) |=> !busy_ff)
      else $error("job still busy after its last phase");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pop)
      else $error("queue popped during a job");

endmodule

`default_nettype wire
